### src/csq_pkg.sv
// types, constants and codes shared by the semaphore wait queue block
`default_nettype none
package csq_pkg;

  localparam int NUM_SEMS    = 8;
  localparam int QUEUE_DEPTH = 16;
  localparam int PID_WIDTH   = 8;

  localparam int SEM_IDX_W = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam int PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int FILL_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int STORE_D   = NUM_SEMS * QUEUE_DEPTH;
  localparam int ADDR_W    = $clog2(STORE_D);
  localparam int STORE_W   = (PID_WIDTH < 8) ? PID_WIDTH : 8;
  localparam int COUNT_W   = 8;

  typedef enum logic [1:0] {
    OP_WAIT   = 2'd0,
    OP_SIGNAL = 2'd1,
    OP_LOAD   = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_PROCEED   = 3'd0,
    ST_BLOCKED   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_DONE      = 3'd4
  } status_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] sem_index;
    logic [7:0] pid;
    logic [6:0] init_value;
  } in_word_t;

  typedef struct packed {
    status_t    status;
    logic       wake_valid;
    logic [7:0] wake_pid;
  } out_word_t;

  typedef struct packed {
    status_t status;
    logic    wake_valid;
  } resp_t;

  typedef struct packed {
    logic               we;
    logic               re;
    logic [ADDR_W-1:0]  addr;
    logic [STORE_W-1:0] wdata;
  } ram_ctrl_t;

endpackage
`default_nettype wire

### src/csq_ram.sv
// generic single-port-per-direction ram with registered read
`default_nettype none
module csq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### src/csq_state.sv
// semaphore counts, queue pointers and per-request decision logic
`default_nettype none
module csq_state (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                fire,
  input  wire csq_pkg::in_word_t   req,
  input  wire logic [3:0]          sem_count,
  output csq_pkg::resp_t           resp,
  output csq_pkg::ram_ctrl_t       ram
);

  logic signed [csq_pkg::COUNT_W-1:0] counts [csq_pkg::NUM_SEMS];
  logic [csq_pkg::PTR_W-1:0]          heads  [csq_pkg::NUM_SEMS];
  logic [csq_pkg::PTR_W-1:0]          tails  [csq_pkg::NUM_SEMS];
  logic [csq_pkg::FILL_W-1:0]         fills  [csq_pkg::NUM_SEMS];

  logic                               idx_ok;
  logic [csq_pkg::SEM_IDX_W-1:0]      sel;
  logic signed [csq_pkg::COUNT_W-1:0] cnt;
  logic [csq_pkg::PTR_W-1:0]          head;
  logic [csq_pkg::PTR_W-1:0]          tail;
  logic [csq_pkg::FILL_W-1:0]         fill;
  logic [csq_pkg::ADDR_W-1:0]         base;

  logic signed [csq_pkg::COUNT_W-1:0] count_next;
  logic [csq_pkg::PTR_W-1:0]          head_next;
  logic [csq_pkg::PTR_W-1:0]          tail_next;
  logic [csq_pkg::FILL_W-1:0]         fill_next;
  logic                               upd;

  assign idx_ok = ({1'b0, req.sem_index} < {1'b0, sem_count}) &&
                  ({1'b0, req.sem_index} < 5'(csq_pkg::NUM_SEMS));
  assign sel    = req.sem_index[csq_pkg::SEM_IDX_W-1:0];
  assign cnt    = counts[sel];
  assign head   = heads[sel];
  assign tail   = tails[sel];
  assign fill   = fills[sel];
  assign base   = csq_pkg::ADDR_W'(sel) * csq_pkg::ADDR_W'(csq_pkg::QUEUE_DEPTH);

  always_comb begin
    resp.status     = csq_pkg::ST_NOT_FOUND;
    resp.wake_valid = 1'b0;
    ram.we          = 1'b0;
    ram.re          = 1'b0;
    ram.addr        = base + csq_pkg::ADDR_W'(head);
    ram.wdata       = req.pid[csq_pkg::STORE_W-1:0];
    count_next      = cnt;
    head_next       = head;
    tail_next       = tail;
    fill_next       = fill;
    upd             = 1'b0;
    if (idx_ok) begin
      case (req.op)
        csq_pkg::OP_LOAD: begin
          upd         = 1'b1;
          count_next  = {1'b0, req.init_value};
          resp.status = csq_pkg::ST_DONE;
        end
        csq_pkg::OP_WAIT: begin
          if (cnt > 8'sd0) begin
            upd         = 1'b1;
            count_next  = cnt - 8'sd1;
            resp.status = csq_pkg::ST_PROCEED;
          end else if (fill == csq_pkg::FILL_W'(csq_pkg::QUEUE_DEPTH)) begin
            resp.status = csq_pkg::ST_FULL;
          end else begin
            upd         = 1'b1;
            ram.we      = 1'b1;
            ram.addr    = base + csq_pkg::ADDR_W'(tail);
            tail_next   = (tail == csq_pkg::PTR_W'(csq_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : tail + 1'b1;
            fill_next   = fill + 1'b1;
            if (cnt != -8'sd128) begin
              count_next = cnt - 8'sd1;
            end
            resp.status = csq_pkg::ST_BLOCKED;
          end
        end
        csq_pkg::OP_SIGNAL: begin
          upd         = 1'b1;
          resp.status = csq_pkg::ST_DONE;
          if (cnt != 8'sd127) begin
            count_next = cnt + 8'sd1;
          end
          if (fill != '0) begin
            ram.re          = 1'b1;
            resp.wake_valid = 1'b1;
            head_next       = (head == csq_pkg::PTR_W'(csq_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : head + 1'b1;
            fill_next       = fill - 1'b1;
          end
        end
        default: begin
          resp.status = csq_pkg::ST_NOT_FOUND;
        end
      endcase
    end
    if (!fire) begin
      ram.we = 1'b0;
      ram.re = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < csq_pkg::NUM_SEMS; i++) begin
        counts[i] <= '0;
        heads[i]  <= '0;
        tails[i]  <= '0;
        fills[i]  <= '0;
      end
    end else if (fire && upd) begin
      counts[sel] <= count_next;
      heads[sel]  <= head_next;
      tails[sel]  <= tail_next;
      fills[sel]  <= fill_next;
    end
  end

endmodule
`default_nettype wire

### src/counting_semaphore_wait_queue.sv
// top level: bank of counting semaphores with fifo wait queues
//
// one request word in, one result word out, in order. in_data carries
// op, sem_index, pid and init_value; out_data carries status, wake_valid
// and wake_pid (zero when no waiter is woken).
// a word is taken when in_valid is high and in_stall low, and a result
// leaves when out_valid is high and out_stall low.
// from acceptance to out_valid a word passes an input register, then
// the decision on the named semaphore's count and queue ends, which
// writes the queue ram or starts its registered read, then the result
// register. throughput is one word per cycle while out_stall stays low,
// set by the single queue ram access per request.
// a stalled result holds; the input register keeps taking a word each cycle
// the result register can drain, so in_stall only rises while a result
// waits and a second word is already held.
// synchronous reset clears counts, queue pointers and fills, and sem_count;
// queue ram contents are only read after being written. the user must let
// cfg_wr_en write sem_count only while the block is idle; it is unchecked.
`default_nettype none
module counting_semaphore_wait_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire csq_pkg::in_word_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output csq_pkg::out_word_t       out_data,
  input  wire logic                cfg_wr_en,
  input  wire logic [3:0]          cfg_wr_data
);

  logic                         a_valid;
  csq_pkg::in_word_t            a_word;
  logic                         b_valid;
  csq_pkg::status_t             b_status;
  logic                         b_wake_valid;
  logic [3:0]                   sem_count;
  logic                         fire;
  csq_pkg::resp_t               resp;
  csq_pkg::ram_ctrl_t           ram;
  logic [csq_pkg::STORE_W-1:0]  rdata;

  assign fire     = a_valid && !(b_valid && out_stall);
  assign in_stall = a_valid && b_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      sem_count <= '0;
    end else if (cfg_wr_en) begin
      sem_count <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (!in_stall) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      a_word <= in_data;
    end
  end

  csq_state u_state (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .req       (a_word),
    .sem_count (sem_count),
    .resp      (resp),
    .ram       (ram)
  );

  csq_ram #(
    .WIDTH (csq_pkg::STORE_W),
    .DEPTH (csq_pkg::STORE_D)
  ) u_ram (
    .clk   (clk),
    .we    (ram.we),
    .waddr (ram.addr),
    .wdata (ram.wdata),
    .re    (ram.re),
    .raddr (ram.addr),
    .rdata (rdata)
  );

  // result register; ram read data holds until the next wake
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (fire) begin
      b_valid <= 1'b1;
    end else if (!out_stall) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      b_status     <= resp.status;
      b_wake_valid <= resp.wake_valid;
    end
  end

  assign out_valid           = b_valid;
  assign out_data.status     = b_status;
  assign out_data.wake_valid = b_wake_valid;
  assign out_data.wake_pid   = b_wake_valid ? 8'(rdata) : 8'd0;

  a_ram_one_access: assert property (@(posedge clk) disable iff (rst)
    !(ram.we && ram.re))
    else $error("queue ram written and read in one cycle");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall && a_valid))
    else $error("input stalled without a waiting result");

  a_wake_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data.wake_pid)))
    else $error("woken pid changed while result stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !a_valid))
    else $error("pipeline not empty after reset");

endmodule
`default_nettype wire
